### rtl/ess_pkg.sv
`default_nettype none

package ess_pkg;

   typedef enum logic [1:0] {
      CMD_EDGE      = 2'd0,
      CMD_TICK      = 2'd1,
      CMD_SET_GOAL  = 2'd2,
      CMD_SET_PULSE = 2'd3
   } cmd_type;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_RPM_PER_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_PER_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_PULSE     = 2'd2;

   localparam logic [15:0] RPM_PER_COUNT_RST  = 16'd256;
   localparam logic [15:0] DIST_PER_COUNT_RST = 16'd256;
   localparam logic [11:0] STOP_PULSE_RST     = 12'd1500;

   localparam logic [11:0] PULSE_LOW  = 12'd1010;
   localparam logic [11:0] PULSE_HIGH = 12'd1990;

   localparam logic [39:0] TRAVEL_MAX = {1'b0, {39{1'b1}}};
   localparam logic [39:0] TRAVEL_MIN = {1'b1, {39{1'b0}}};

endpackage

`default_nettype wire

### rtl/encoder_speed_stepper.sv
// encoder_speed_stepper: speed, travel and a slow pulse-width step loop for a
// quadrature encoder driven motor.
//
// Input channel req_*: one item per event; req_tuser carries the command
// (encoder edge, period tick, set target, set pulse), req_tdata the phase B
// level, target speed and pulse width. Result channel rsp_*: exactly one item
// per input item, giving the driven pulse, the last measured speed, the
// integer travel and the edges counted since the last tick.
// Configuration: csr_write with csr_index and csr_data, no read-back; the user
// must make writes while no item is in flight; the block leaves it unchecked.
// Writing the stop pulse also loads the ramp and driven pulse.
// An accepted input item is held in the input register, then the state update
// writes its result into the result register.
// Throughput: one item per cycle unless the receiver stalls; the two 16 x 16
// products and the 40-bit travel add of a period tick sit in the single stage
// after the input register; the state they update is ready for the next item.
// Reset (synchronous, active high) restores all register defaults, clears
// counts, travel and the loop flag and empties both stages.
// When the receiver stalls, the result is held and one further item is
// taken into the input register; req_tready then falls until rsp_tready.
`default_nettype none

module encoder_speed_stepper
   import ess_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // encoder_b, target_rpm[11:0], pulse_us[11:0], zero fill
   input  wire logic [31:0]            req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]             req_tuser,

   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // drive_pulse[11:0], measured_rpm[15:0], distance[31:0],
   // pending_edges[15:0], zero fill
   output logic [79:0]                 rsp_tdata,

   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration
   logic [15:0] rpm_per_count_ff, rpm_per_count_in;
   logic [15:0] dist_per_count_ff, dist_per_count_in;
   logic [11:0] stop_pulse_ff, stop_pulse_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   cmd_type     in_cmd_ff;
   logic        in_b_ff;
   logic [11:0] in_target_ff;
   logic [11:0] in_pulse_ff;

   // state
   logic [15:0] edge_count_ff, edge_count_in;
   logic        direction_back_ff, direction_back_in;
   logic [11:0] goal_speed_ff, goal_speed_in;
   logic [11:0] ramp_pulse_ff, ramp_pulse_in;
   logic [11:0] driven_pulse_ff, driven_pulse_in;
   logic        loop_enabled_ff, loop_enabled_in;
   logic [15:0] speed_now_ff, speed_now_in;
   logic [39:0] travel_acc_ff, travel_acc_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_pulse_ff;
   logic [15:0] rsp_rpm_ff;
   logic [39:0] rsp_travel_ff;
   logic [15:0] rsp_edges_ff;

   logic        advance;
   logic        fire;
   logic        req_accept;
   logic [31:0] speed_q;
   logic [31:0] travel_step;
   logic [31:0] goal_q;
   logic [40:0] travel_fwd;
   logic [40:0] travel_back;
   logic        step_ok;
   logic        step_up;
   logic [39:0] travel_round;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign speed_q     = {16'b0, edge_count_ff} * {16'b0, rpm_per_count_ff};
   assign travel_step = {16'b0, edge_count_ff} * {16'b0, dist_per_count_ff};
   assign goal_q      = {12'b0, goal_speed_ff, 8'b0};
   assign travel_fwd  = {travel_acc_ff[39], travel_acc_ff} + {9'b0, travel_step};
   assign travel_back = {travel_acc_ff[39], travel_acc_ff} - {9'b0, travel_step};

   assign step_ok = loop_enabled_ff && (speed_q != 32'd0)
                    && (ramp_pulse_ff > PULSE_LOW) && (ramp_pulse_ff < PULSE_HIGH)
                    && (speed_q != goal_q);
   assign step_up = (speed_q < goal_q) != direction_back_ff;

   always_comb begin
      rpm_per_count_in  = rpm_per_count_ff;
      dist_per_count_in = dist_per_count_ff;
      stop_pulse_in     = stop_pulse_ff;
      edge_count_in     = edge_count_ff;
      direction_back_in = direction_back_ff;
      goal_speed_in     = goal_speed_ff;
      ramp_pulse_in     = ramp_pulse_ff;
      driven_pulse_in   = driven_pulse_ff;
      loop_enabled_in   = loop_enabled_ff;
      speed_now_in      = speed_now_ff;
      travel_acc_in     = travel_acc_ff;

      if (fire) begin
         unique case (in_cmd_ff)
            CMD_EDGE: begin
               direction_back_in = !in_b_ff;
               if (edge_count_ff != 16'hFFFF) begin
                  edge_count_in = edge_count_ff + 16'd1;
               end
            end
            CMD_TICK: begin
               speed_now_in = (speed_q[31:24] != 8'd0) ? 16'hFFFF : speed_q[23:8];
               if (direction_back_ff) begin
                  travel_acc_in = (travel_back[40] != travel_back[39]) ?
                                  TRAVEL_MIN : travel_back[39:0];
               end else begin
                  travel_acc_in = (travel_fwd[40] != travel_fwd[39]) ?
                                  TRAVEL_MAX : travel_fwd[39:0];
               end
               if (step_ok) begin
                  ramp_pulse_in   = step_up ? ramp_pulse_ff + 12'd1 : ramp_pulse_ff - 12'd1;
                  driven_pulse_in = ramp_pulse_in;
               end
               edge_count_in = 16'd0;
            end
            CMD_SET_GOAL: begin
               loop_enabled_in = 1'b1;
               goal_speed_in   = in_target_ff;
               ramp_pulse_in   = in_pulse_ff;
               driven_pulse_in = in_pulse_ff;
            end
            CMD_SET_PULSE: begin
               loop_enabled_in = 1'b0;
               driven_pulse_in = in_pulse_ff;
            end
            default: begin
               loop_enabled_in = loop_enabled_ff;
            end
         endcase
      end

      if (csr_write) begin
         priority case (csr_index)
            CSR_RPM_PER_COUNT: begin
               rpm_per_count_in = csr_data;
            end
            CSR_DIST_PER_COUNT: begin
               dist_per_count_in = csr_data;
            end
            CSR_STOP_PULSE: begin
               stop_pulse_in   = csr_data[11:0];
               ramp_pulse_in   = csr_data[11:0];
               driven_pulse_in = csr_data[11:0];
            end
            default: begin
               stop_pulse_in = stop_pulse_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpm_per_count_ff  <= RPM_PER_COUNT_RST;
         dist_per_count_ff <= DIST_PER_COUNT_RST;
         stop_pulse_ff     <= STOP_PULSE_RST;
         in_valid_ff       <= 1'b0;
         edge_count_ff     <= 16'd0;
         direction_back_ff <= 1'b0;
         goal_speed_ff     <= 12'd0;
         ramp_pulse_ff     <= STOP_PULSE_RST;
         driven_pulse_ff   <= STOP_PULSE_RST;
         loop_enabled_ff   <= 1'b0;
         speed_now_ff      <= 16'd0;
         travel_acc_ff     <= 40'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rpm_per_count_ff  <= rpm_per_count_in;
         dist_per_count_ff <= dist_per_count_in;
         stop_pulse_ff     <= stop_pulse_in;
         in_valid_ff       <= in_valid_in;
         edge_count_ff     <= edge_count_in;
         direction_back_ff <= direction_back_in;
         goal_speed_ff     <= goal_speed_in;
         ramp_pulse_ff     <= ramp_pulse_in;
         driven_pulse_ff   <= driven_pulse_in;
         loop_enabled_ff   <= loop_enabled_in;
         speed_now_ff      <= speed_now_in;
         travel_acc_ff     <= travel_acc_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff    <= cmd_type'(req_tuser);
         in_b_ff      <= req_tdata[0];
         in_target_ff <= req_tdata[12:1];
         in_pulse_ff  <= req_tdata[24:13];
      end
      if (fire) begin
         rsp_pulse_ff  <= driven_pulse_in;
         rsp_rpm_ff    <= speed_now_in;
         rsp_travel_ff <= travel_acc_in;
         rsp_edges_ff  <= edge_count_in;
      end
   end

   // integer part of travel, truncated toward zero
   assign travel_round = rsp_travel_ff + (rsp_travel_ff[39] ? 40'd255 : 40'd0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_edges_ff, travel_round[39:8], rsp_rpm_ff, rsp_pulse_ff};

   a_tick_clears_count: assert property (@(posedge clock) disable iff (reset)
      fire && (in_cmd_ff == CMD_TICK) |=> (edge_count_ff == 16'd0))
      else $error("edge count not cleared by tick");

   a_set_pulse_opens_loop: assert property (@(posedge clock) disable iff (reset)
      fire && (in_cmd_ff == CMD_SET_PULSE) |=> !loop_enabled_ff)
      else $error("loop still enabled after set pulse");

   a_ramp_single_step: assert property (@(posedge clock) disable iff (reset)
      fire && (in_cmd_ff == CMD_TICK) |=>
         (ramp_pulse_ff == $past(ramp_pulse_ff))
         || (ramp_pulse_ff == $past(ramp_pulse_ff) + 12'd1)
         || (ramp_pulse_ff == $past(ramp_pulse_ff) - 12'd1))
      else $error("ramp pulse moved by more than one on a tick");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while result side is ready");

   a_stage_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("stalled item dropped from input register");

endmodule

`default_nettype wire
